// ===== design/sorted_priority_queue_macros.svh =====
// Assertion macros shared by the checker of the sorted priority queue.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== design/spq_pkg.sv =====
// Package of the sorted priority queue: entry and command types, codes.
// Depends on nothing; used by the cell, the top level and the checker.
`default_nettype none

package spq_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [7:0]  prio;
  } spq_entry_t;

  // Broadcast from the top level to every cell in the row.
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// One slot of the sorted row: holds an entry and its valid bit.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  spq_cmd_t   cmd_i,
  input  spq_entry_t left_entry_i,
  input  wire        left_valid_i,
  input  wire        left_keep_i,
  input  spq_entry_t right_entry_i,
  input  wire        right_valid_i,
  output spq_entry_t entry_o,
  output logic       valid_o,
  output logic       keep_o
);

  spq_entry_t entry_q, entry_d;
  logic       valid_q, valid_d;

  // The cell keeps its entry on an insert when the entry stays ahead of the
  // new one: equal priorities keep arrival order.
  assign keep_o = valid_q && (entry_q.prio >= cmd_i.entry.prio);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.insert && !keep_o) begin
      if (left_keep_i) begin
        entry_d = cmd_i.entry;
        valid_d = 1'b1;
      end else begin
        entry_d = left_entry_i;
        valid_d = left_valid_i;
      end
    end else if (cmd_i.remove) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell slots, the
// entry count and the result register. Depends on spq_pkg and spq_cell.
//
// A bounded priority queue built as a row of CAPACITY cells that always
// hold the entries in service order, head in cell zero. Each item either
// inserts a value with an 8-bit priority or removes the head entry. On an
// insert every cell compares its priority with the new one at the same
// time; cells ahead of the insertion point hold, the cell at the point
// takes the new entry and the cells behind it take their left neighbor's
// entry. On a remove every cell takes its right neighbor's entry. Higher
// priority goes first, and entries of equal priority leave in the order
// they arrived. An insert into a full queue or a remove from an empty one
// leaves the queue unchanged and reports a status code. Every item gives
// exactly one result in the cycle after it is accepted, and the queue takes one
// item per cycle: the result sits in an output register, and a new item is
// accepted whenever that register is empty or is being emptied in the same
// cycle. The critical path is the priority compare in each cell plus the
// broadcast of the new entry across the row. The occupancy field reports
// the entry count modulo 32. No clearing pass is needed after reset.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                func_i,
  input  wire signed [31:0]  in_value_i,
  input  wire        [7:0]   in_priority_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] out_value_o,
  output logic       [7:0]   out_priority_o,
  output logic       [1:0]   status_o,
  output logic       [OCC_W-1:0] occupancy_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic        accept;
  logic        full;
  logic        empty;
  spq_cmd_t    cmd;

  logic [CntW-1:0] count_q, count_d;

  spq_entry_t  cell_entry [CAPACITY];
  logic        cell_valid [CAPACITY];
  logic        cell_keep  [CAPACITY];

  logic               out_valid_q;
  logic signed [31:0] out_value_q, out_value_d;
  logic        [7:0]  out_prio_q, out_prio_d;
  spq_status_e        status_q, status_d;
  logic [CntW+OCC_W-1:0] occ_wide;

  // The input waits only while a result is held and not being taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    cmd.insert      = accept && (func_i == FUNC_INSERT) && !full;
    cmd.remove      = accept && (func_i == FUNC_REMOVE) && !empty;
    cmd.entry.value = in_value_i;
    cmd.entry.prio  = in_priority_i;
  end

  // The row of cells. Cell zero sees a left neighbor that always keeps, so
  // the new entry lands there when every held entry ranks below it. The
  // last cell sees an empty right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_entry, right_entry;
    logic       left_valid, left_keep, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_entry_i (left_entry),
      .left_valid_i (left_valid),
      .left_keep_i  (left_keep),
      .right_entry_i(right_entry),
      .right_valid_i(right_valid),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // Next count and the fields of the result for the accepted item.
  always_comb begin
    count_d     = count_q;
    out_value_d = '0;
    out_prio_d  = '0;
    status_d    = ST_INSERTED;
    case (func_i)
      FUNC_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d  = count_q + CntW'(1);
          status_d = ST_INSERTED;
        end
      end
      FUNC_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d     = count_q - CntW'(1);
          out_value_d = cell_entry[0].value;
          out_prio_d  = cell_entry[0].prio;
          status_d    = ST_REMOVED;
        end
      end
      default: begin
        status_d = ST_INSERTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the count register already holds the occupancy after
  // the item once the result is shown.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      out_prio_q  <= out_prio_d;
      status_q    <= status_d;
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_q};

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_prio_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_wide[OCC_W-1:0];

endmodule

`default_nettype wire

// ===== design/spq_chk.sv =====
// Port-level checker of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module spq_chk
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire signed [31:0] out_value_o,
  input wire        [7:0]  out_priority_o,
  input wire        [1:0]  status_o,
  input wire   [OCC_W-1:0] occupancy_o
);

  localparam logic [31:0] CapWide = 32'(CAPACITY);
  localparam logic [OCC_W-1:0] CapOcc = CapWide[OCC_W-1:0];

  logic no_payload;

  assign no_payload = (out_value_o == 32'sd0) && (out_priority_o == 8'd0);

  // A held result stays until it is taken.
  `SPQ_ASSERT_NXT(a_hold_result, out_valid_o && out_stall_i, out_valid_o)

  // An accepted item always produces a result in the next cycle.
  `SPQ_ASSERT_NXT(a_one_result, in_valid_i && !in_stall_o, out_valid_o)

  // A rejected insert means the queue is at capacity.
  `SPQ_ASSERT_IMP(a_full_occ, out_valid_o && (status_o == ST_FULL), occupancy_o == CapOcc)

  // Only a successful remove carries a value and a priority.
  `SPQ_ASSERT_IMP(a_no_payload, out_valid_o && (status_o != ST_REMOVED), no_payload)

  // A rejected remove means the queue holds nothing.
  `SPQ_ASSERT_IMP(a_empty_occ, out_valid_o && (status_o == ST_EMPTY), occupancy_o == '0)

endmodule

bind sorted_priority_queue spq_chk #(.CAPACITY(CAPACITY)) u_spq_chk (.*);

`default_nettype wire
